// ===== sv/pbid_pkg.sv =====
// shared types and constants of the packet buffer id table
package pbid_pkg;

	localparam logic [1:0] KIND_SAVE     = 2'd0;
	localparam logic [1:0] KIND_RETRIEVE = 2'd1;
	localparam logic [1:0] KIND_DISCARD  = 2'd2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_SLOT = 2'd1;
	localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
	localparam logic [1:0] STATUS_EMPTY   = 2'd3;

	localparam logic [15:0] HOLD_RESET = 16'd5000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] buffer_id;
		logic [15:0] port_in;
		logic [39:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] id_out;
		logic        has_packet;
		logic [15:0] port_out;
		logic [8:0]  occupied;
	} rsp_t;

	// classified request as it waits for the slot engine
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] buffer_id;
		logic [15:0] port_in;
		logic [39:0] now_ms;
		logic [39:0] expiry;
	} cmd_t;

endpackage

// ===== sv/packet_buffer_id_table.sv =====
// packet buffer id table: hands out and checks generational ids for buffered packets
//
// requests arrive on req_valid / req_stall / req (save, retrieve or discard);
// one result per request leaves on rsp_valid / rsp_stall / rsp in request order.
// cfg_we with cfg_wdata sets the hold time in ms; write it only while idle.
// an intake stage computes the save slot and the saturated expiry and puts the
// request in a two-entry queue; the slot engine reads the slot's cookie, flag,
// expiry and port in its fetch state and writes it back with the result in its
// exec state, which waits while a valid result is stalled. the engine pops the
// next request only after that write, so it takes no new request before it is
// through with the last one.
// after reset the engine clears the flag and cookie of every slot, one a cycle,
// through all 2**SLOT_BITS slots (256 at the default); requests stall until
// that pass ends, and the hold time returns to 5000 ms.
// while rsp_stall is high the result register holds, the engine waits with the
// next request and the queue fills; req_stall rises once the queue is full.
// the slot number in id_out addresses an external payload memory.
module packet_buffer_id_table #(
	parameter int SLOT_BITS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata,
	input  logic            req_valid,
	output logic            req_stall,
	input  pbid_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output pbid_pkg::rsp_t  rsp
);

	pbid_pkg::cmd_t push_data;
	pbid_pkg::cmd_t pop_data;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_empty;
	logic           busy_clear;

	pbid_front #(
		.SLOT_BITS(SLOT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_full    (q_full),
		.busy_clear(busy_clear),
		.q_push    (push),
		.q_data    (push_data)
	);

	pbid_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (q_empty)
	);

	pbid_back #(
		.SLOT_BITS(SLOT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.q_pop     (pop),
		.busy_clear(busy_clear),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== sv/pbid_front.sv =====
// request intake: save slot pointer, hold time register and expiry sum
module pbid_front #(
	parameter int SLOT_BITS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [15:0]     cfg_wdata,
	input  logic            req_valid,
	output logic            req_stall,
	input  pbid_pkg::req_t  req,
	input  logic            q_full,
	input  logic            busy_clear,
	output logic            q_push,
	output pbid_pkg::cmd_t  q_data
);

	logic [SLOT_BITS-1:0] next_slot_q;
	logic [15:0]          hold_q;
	logic [40:0]          exp_sum;
	logic                 is_save;

	assign req_stall = q_full || busy_clear;
	assign q_push    = req_valid && !req_stall;
	assign is_save   = (req.kind == pbid_pkg::KIND_SAVE);

	// expiry saturates at the top of the time range
	assign exp_sum = {1'b0, req.now_ms} + 41'(hold_q);

	always_comb begin
		q_data.kind      = req.kind;
		q_data.buffer_id = is_save ? 32'(next_slot_q) : req.buffer_id;
		q_data.port_in   = req.port_in;
		q_data.now_ms    = req.now_ms;
		q_data.expiry    = exp_sum[40] ? '1 : exp_sum[39:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_slot_q <= '0;
			hold_q      <= pbid_pkg::HOLD_RESET;
		end else begin
			if (cfg_we) begin
				hold_q <= cfg_wdata;
			end
			if (q_push && is_save) begin
				next_slot_q <= next_slot_q + 1'b1;
			end
		end
	end

endmodule

// ===== sv/pbid_queue.sv =====
// two-entry request queue between intake and slot engine
module pbid_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pbid_pkg::cmd_t  push_data,
	output logic            full,
	input  logic            pop,
	output pbid_pkg::cmd_t  pop_data,
	output logic            empty
);

	pbid_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== sv/pbid_back.sv =====
// slot engine: slot memories, cookie checks, occupied count and result register
module pbid_back #(
	parameter int SLOT_BITS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  pbid_pkg::cmd_t  q_data,
	output logic            q_pop,
	output logic            busy_clear,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output pbid_pkg::rsp_t  rsp
);

	localparam int CW    = 32 - SLOT_BITS;
	localparam int SLOTS = 1 << SLOT_BITS;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_FETCH = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t state_q;

	// meta entry: full flag on top of the cookie
	logic [CW:0]  meta_mem [SLOTS];
	logic [55:0]  data_mem [SLOTS];
	logic [CW:0]  meta_rd_q;
	logic [55:0]  data_rd_q;

	pbid_pkg::cmd_t       cmd_q;
	pbid_pkg::rsp_t       rsp_q;
	logic                 rsp_valid_q;
	logic [SLOT_BITS-1:0] clr_q;
	logic [SLOT_BITS:0]   count_q;

	logic [SLOT_BITS:0]   count_nxt;
	logic [SLOT_BITS-1:0] slot;
	logic [CW-1:0]        id_ck;
	logic                 rd_full;
	logic [CW-1:0]        rd_ck;
	logic [39:0]          rd_exp;
	logic [15:0]          rd_port;
	logic [CW-1:0]        ck_inc;
	logic [CW-1:0]        ck_new;
	logic [CW:0]          meta_wdata;
	logic                 meta_upd;
	logic                 data_upd;
	logic                 exec_fire;
	logic                 meta_we;
	logic [SLOT_BITS-1:0] meta_addr;
	logic [CW:0]          meta_wval;
	pbid_pkg::rsp_t       res;

	assign busy_clear = (state_q == ST_CLEAR);
	assign q_pop      = (state_q == ST_FETCH) && !q_empty;
	assign exec_fire  = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	assign slot    = cmd_q.buffer_id[SLOT_BITS-1:0];
	assign id_ck   = cmd_q.buffer_id[31:SLOT_BITS];
	assign rd_full = meta_rd_q[CW];
	assign rd_ck   = meta_rd_q[CW-1:0];
	assign rd_exp  = data_rd_q[55:16];
	assign rd_port = data_rd_q[15:0];
	assign ck_inc  = rd_ck + 1'b1;
	// the all-ones cookie is never stored
	assign ck_new  = (ck_inc == '1) ? '0 : ck_inc;

	always_comb begin
		res        = '0;
		meta_wdata = meta_rd_q;
		meta_upd   = 1'b0;
		data_upd   = 1'b0;
		count_nxt  = count_q;
		unique case (cmd_q.kind)
			pbid_pkg::KIND_SAVE: begin
				if (rd_full && (cmd_q.now_ms < rd_exp)) begin
					res.status = pbid_pkg::STATUS_NO_SLOT;
					res.id_out = '1;
				end else begin
					meta_wdata = {1'b1, ck_new};
					meta_upd   = 1'b1;
					data_upd   = 1'b1;
					if (!rd_full) begin
						count_nxt = count_q + 1'b1;
					end
					res.status = pbid_pkg::STATUS_OK;
					res.id_out = {ck_new, slot};
				end
			end
			pbid_pkg::KIND_RETRIEVE: begin
				if (cmd_q.buffer_id == '1) begin
					res.status = pbid_pkg::STATUS_OK;
				end else if (rd_ck == id_ck) begin
					if (rd_full) begin
						res.has_packet = 1'b1;
						res.port_out   = rd_port;
						meta_wdata     = {1'b0, rd_ck};
						meta_upd       = 1'b1;
						count_nxt      = count_q - 1'b1;
					end else begin
						res.status = pbid_pkg::STATUS_EMPTY;
					end
				end else if (id_ck != '1) begin
					res.status = pbid_pkg::STATUS_UNKNOWN;
				end
			end
			pbid_pkg::KIND_DISCARD: begin
				if ((rd_ck == id_ck) && rd_full) begin
					meta_wdata = {1'b0, rd_ck};
					meta_upd   = 1'b1;
					count_nxt  = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.occupied = 9'(count_nxt);
	end

	assign meta_we   = busy_clear || (exec_fire && meta_upd);
	assign meta_addr = busy_clear ? clr_q : slot;
	assign meta_wval = busy_clear ? '0 : meta_wdata;

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[meta_addr] <= meta_wval;
		end
		if (exec_fire && data_upd) begin
			data_mem[slot] <= {cmd_q.expiry, cmd_q.port_in};
		end
		if (q_pop) begin
			meta_rd_q <= meta_mem[q_data.buffer_id[SLOT_BITS-1:0]];
			data_rd_q <= data_mem[q_data.buffer_id[SLOT_BITS-1:0]];
			cmd_q     <= q_data;
		end
		if (exec_fire) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (exec_fire) begin
				rsp_valid_q <= 1'b1;
				count_q     <= count_nxt;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (!q_empty) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_fire) begin
						state_q <= ST_FETCH;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

endmodule

// ===== test/tb_packet_buffer_id_table.sv =====
// testbench for the packet buffer id table: random and directed requests checked against a predictor
`timescale 1ns / 100ps

module tb_packet_buffer_id_table;

	localparam int SLOT_BITS = 8;
	localparam int SLOTS     = 1 << SLOT_BITS;
	localparam int CK_WIDTH  = 32 - SLOT_BITS;

	localparam logic [1:0]          KIND_UNUSED = 2'd3;
	localparam logic [CK_WIDTH-1:0] COOKIE_NULL = '1;
	localparam logic [31:0]         ALL_ONES_ID = 32'hFFFF_FFFF;
	localparam logic [39:0]         TIME_MAX    = '1;

	class slot_table_scoreboard;
		logic                   slot_full   [SLOTS];
		logic [CK_WIDTH-1:0]    slot_cookie [SLOTS];
		logic [39:0]            slot_expiry [SLOTS];
		logic [15:0]            slot_port   [SLOTS];
		logic [SLOT_BITS-1:0]   next_slot;
		logic [8:0]             full_count;
		logic [15:0]            hold_ms;
		pbid_pkg::rsp_t         expected_rsp_q[$];
		logic [31:0]            issued_ids[$];
		int errors, checked, peak_occupied;
		int n_save, n_held, n_saturated, n_retrieve, n_handed, n_discard, n_unused;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				slot_full[i]   = 1'b0;
				slot_cookie[i] = '0;
				slot_expiry[i] = '0;
				slot_port[i]   = '0;
			end
			next_slot  = '0;
			full_count = '0;
			hold_ms    = pbid_pkg::HOLD_RESET;
		endfunction

		function int pending();
			return expected_rsp_q.size();
		endfunction

		function void vacate(logic [SLOT_BITS-1:0] s);
			if (slot_full[s]) begin
				slot_full[s] = 1'b0;
				full_count--;
			end
		endfunction

		// predict the result of one accepted request and advance the table
		function void note_request(pbid_pkg::req_t r);
			pbid_pkg::rsp_t         want;
			logic [SLOT_BITS-1:0]   s;
			logic [SLOT_BITS-1:0]   t;
			logic [CK_WIDTH-1:0]    ck;
			logic [CK_WIDTH-1:0]    bumped;
			logic [40:0]            sum;
			want = '0;
			s  = r.buffer_id[SLOT_BITS-1:0];
			ck = r.buffer_id[31:SLOT_BITS];
			case (r.kind)
			pbid_pkg::KIND_SAVE: begin
				n_save++;
				t = next_slot;
				next_slot = t + 1'b1;
				if (slot_full[t] && r.now_ms < slot_expiry[t]) begin
					n_held++;
					want.status = pbid_pkg::STATUS_NO_SLOT;
					want.id_out = ALL_ONES_ID;
				end else begin
					bumped = slot_cookie[t] + 1'b1;
					// the all-ones cookie is the null cookie and is never stored
					if (bumped == COOKIE_NULL)
						bumped = '0;
					slot_cookie[t] = bumped;
					if (!slot_full[t]) begin
						slot_full[t] = 1'b1;
						full_count++;
					end
					sum = {1'b0, r.now_ms} + 41'(hold_ms);
					if (sum[40])
						n_saturated++;
					slot_expiry[t] = sum[40] ? TIME_MAX : sum[39:0];
					slot_port[t]   = r.port_in;
					want.status = pbid_pkg::STATUS_OK;
					want.id_out = {bumped, t};
					issued_ids.push_back(want.id_out);
					if (issued_ids.size() > 64)
						void'(issued_ids.pop_front());
				end
			end
			pbid_pkg::KIND_RETRIEVE: begin
				n_retrieve++;
				if (r.buffer_id != ALL_ONES_ID) begin
					if (slot_cookie[s] == ck) begin
						if (slot_full[s]) begin
							n_handed++;
							want.has_packet = 1'b1;
							want.port_out   = slot_port[s];
							vacate(s);
						end else begin
							want.status = pbid_pkg::STATUS_EMPTY;
						end
					end else if (ck != COOKIE_NULL) begin
						want.status = pbid_pkg::STATUS_UNKNOWN;
					end
				end
			end
			pbid_pkg::KIND_DISCARD: begin
				n_discard++;
				if (slot_cookie[s] == ck)
					vacate(s);
			end
			default: n_unused++;
			endcase
			want.occupied = full_count;
			if (full_count > peak_occupied)
				peak_occupied = full_count;
			expected_rsp_q.push_back(want);
		endfunction

		task report(string what);
			if (errors < 40)
				$display("[%0t] mismatch: %s", $realtime, what);
			errors++;
		endtask

		task check_response(pbid_pkg::rsp_t got);
			pbid_pkg::rsp_t want;
			string          diffs;
			if (expected_rsp_q.size() == 0) begin
				report($sformatf("result status %0d id %h with no request outstanding",
					got.status, got.id_out));
				return;
			end
			want = expected_rsp_q.pop_front();
			checked++;
			diffs = "";
			if (got.status !== want.status)
				diffs = {diffs, $sformatf(" status %0d/%0d", got.status, want.status)};
			if (got.id_out !== want.id_out)
				diffs = {diffs, $sformatf(" id_out %h/%h", got.id_out, want.id_out)};
			if (got.has_packet !== want.has_packet)
				diffs = {diffs, $sformatf(" has_packet %b/%b", got.has_packet, want.has_packet)};
			if (got.port_out !== want.port_out)
				diffs = {diffs, $sformatf(" port_out %h/%h", got.port_out, want.port_out)};
			if (got.occupied !== want.occupied)
				diffs = {diffs, $sformatf(" occupied %0d/%0d", got.occupied, want.occupied)};
			if (diffs != "")
				report($sformatf("result %0d got/want:%s", checked, diffs));
		endtask
	endclass

	logic           clk;
	logic           arst_n    = 1'b0;
	logic           cfg_we    = 1'b0;
	logic [15:0]    cfg_wdata = '0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	pbid_pkg::req_t req       = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	pbid_pkg::rsp_t rsp;

	slot_table_scoreboard table_sb = new();
	logic [39:0] wall_ms = '0;
	bit          calm = 1'b0;
	int          hold_settings = 0;

	packet_buffer_id_table #(
		.SLOT_BITS(SLOT_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	always @(negedge clk) begin
		rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 14);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			table_sb.check_response(rsp);
	end

	function void advance(int unsigned step);
		logic [40:0] sum;
		sum = {1'b0, wall_ms} + 41'(step);
		wall_ms = sum[40] ? TIME_MAX : sum[39:0];
	endfunction

	function automatic pbid_pkg::req_t item(logic [1:0] kind, logic [31:0] id,
		logic [15:0] port);
		pbid_pkg::req_t r;
		r.kind      = kind;
		r.buffer_id = id;
		r.port_in   = port;
		r.now_ms    = wall_ms;
		return r;
	endfunction

	// mostly ids the table handed out recently, the rest null, stale or random ids
	function automatic pbid_pkg::req_t make_request(int save_pct);
		pbid_pkg::req_t r;
		int             pick;
		int             n;
		r.now_ms    = wall_ms;
		r.buffer_id = $urandom;
		pick = $urandom_range(0, 9);
		r.port_in = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
		if ($urandom_range(0, 99) < save_pct) begin
			r.kind = pbid_pkg::KIND_SAVE;
		end else begin
			pick = $urandom_range(0, 99);
			r.kind = (pick < 62) ? pbid_pkg::KIND_RETRIEVE :
				(pick < 96) ? pbid_pkg::KIND_DISCARD : KIND_UNUSED;
			pick = $urandom_range(0, 99);
			n = table_sb.issued_ids.size();
			if (pick < 60 && n > 0)
				r.buffer_id = table_sb.issued_ids[$urandom_range(0, n - 1)];
			else if (pick < 70)
				r.buffer_id = ALL_ONES_ID;
			else if (pick < 80)
				r.buffer_id = {COOKIE_NULL, SLOT_BITS'($urandom)};
			else if (pick < 90)
				r.buffer_id = {CK_WIDTH'($urandom_range(0, 2)), SLOT_BITS'($urandom)};
		end
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after the request is taken
	task automatic send_request(pbid_pkg::req_t r);
		while (!calm && $urandom_range(0, 99) < 14) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (req_stall);
		table_sb.note_request(r);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (table_sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_hold(logic [15:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		table_sb.hold_ms = value;
		hold_settings++;
	endtask

	task automatic run_phase(int count, int save_pct, int step_max);
		int unsigned step;
		repeat (count) begin
			step = $urandom_range(0, step_max);
			if ($urandom_range(0, 99) < 3)
				step += $urandom_range(0, 8000);
			advance(step);
			send_request(make_request(save_pct));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part at time zero with the reset hold time
		send_request(item(pbid_pkg::KIND_RETRIEVE, 32'h0000_0000, 16'h0000));
		send_request(item(pbid_pkg::KIND_RETRIEVE, 32'h0000_00FF, 16'hFFFF));
		send_request(item(pbid_pkg::KIND_SAVE, 32'h0000_0000, 16'h0000));
		send_request(item(pbid_pkg::KIND_SAVE, ALL_ONES_ID, 16'hFFFF));
		send_request(item(pbid_pkg::KIND_SAVE, 32'h0000_0000, 16'h1234));
		send_request(item(pbid_pkg::KIND_RETRIEVE, 32'h0000_0100, 16'h0000));
		send_request(item(pbid_pkg::KIND_RETRIEVE, 32'h0000_0100, 16'h0000));
		send_request(item(pbid_pkg::KIND_RETRIEVE, 32'h0000_0201, 16'h0000));
		send_request(item(pbid_pkg::KIND_RETRIEVE, {COOKIE_NULL, 8'h01}, 16'h0000));
		send_request(item(pbid_pkg::KIND_RETRIEVE, ALL_ONES_ID, 16'h0000));
		send_request(item(pbid_pkg::KIND_DISCARD, 32'h0000_0301, 16'h0000));
		send_request(item(pbid_pkg::KIND_DISCARD, 32'h0000_0101, 16'h0000));
		send_request(item(pbid_pkg::KIND_RETRIEVE, 32'h0000_0101, 16'h0000));
		send_request(item(pbid_pkg::KIND_DISCARD, ALL_ONES_ID, 16'hFFFF));
		send_request(item(KIND_UNUSED, 32'h0000_0102, 16'hFFFF));
		send_request(item(KIND_UNUSED, ALL_ONES_ID, 16'hFFFF));
		send_request(item(pbid_pkg::KIND_RETRIEVE, 32'h0000_0102, 16'h0000));
		send_request(item(pbid_pkg::KIND_SAVE, 32'h0000_0000, 16'hA5A5));
		send_request(item(pbid_pkg::KIND_DISCARD, 32'h0000_0000, 16'h0000));

		// save-heavy with slow time: fills the table and hits held slots
		wall_ms = {1'b0, 7'($urandom_range(0, 127)), 32'($urandom)};
		run_phase(350, 75, 2);

		// zero hold time, every slot can be overwritten at once
		set_hold(16'd0);
		calm = 1'b1;
		run_phase(200, 50, 3);
		calm = 1'b0;

		set_hold(16'($urandom_range(200, 3000)));
		run_phase(300, 55, 20);

		set_hold(16'd1);
		run_phase(150, 50, 1);

		// longest hold near the end of time, so expiry saturates
		set_hold(16'hFFFF);
		wall_ms = TIME_MAX - 40'd60000;
		run_phase(150, 60, 800);

		wait_idle();
		repeat (8) @(negedge clk);
		if (table_sb.pending() != 0)
			table_sb.report($sformatf("%0d results never arrived", table_sb.pending()));

		$display("covered %0d saves (%0d refused on a held slot, %0d with saturated expiry),",
			table_sb.n_save, table_sb.n_held, table_sb.n_saturated);
		$display("  %0d retrieves (%0d packets), %0d discards, %0d unused, peak %0d, %0d holds",
			table_sb.n_retrieve, table_sb.n_handed, table_sb.n_discard, table_sb.n_unused,
			table_sb.peak_occupied, hold_settings);
		if (table_sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
